@@ hdl/filled_circle_rasterizer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the filled circle rasterizer
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef FILLED_CIRCLE_RASTERIZER_MACROS_SVH
`define FILLED_CIRCLE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FCR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define FCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define FCR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FCR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/fcr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants of the filled circle rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcr_pkg;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   // status of the step queue between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam int POINTS_PER_STEP = 8;
   localparam int POINT_IDX_BITS  = $clog2(POINTS_PER_STEP);
   localparam logic [POINT_IDX_BITS-1:0] LAST_POINT = POINT_IDX_BITS'(POINTS_PER_STEP - 1);

endpackage

@@ hdl/fcr_queue.sv @@
// ----------------------------------------------------------------------------
// fcr_queue
// Two-entry queue carrying step jobs from the front to the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "filled_circle_rasterizer_macros.svh"

module fcr_queue #(
   parameter int WIDTH = 41
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output fcr_pkg::q_status_type status
);

   localparam int DEPTH = 2;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    data_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == CNT_BITS'(DEPTH));
      status.empty = (count_ff == '0);
      pop_data     = data_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `FCR_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !status.full)
   `FCR_ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !status.empty)

endmodule

@@ hdl/fcr_front.sv @@
// ----------------------------------------------------------------------------
// fcr_front
// Takes requests, holds the ring state and runs one ring iteration per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "filled_circle_rasterizer_macros.svh"

module fcr_front #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [COORD_BITS-1:0]  req_center_x,
   input  logic [COORD_BITS-1:0]  req_center_y,
   input  logic [RADIUS_BITS-1:0] req_radius,
   input  fcr_pkg::q_status_type  q_status,
   output logic                   push,
   output logic [COORD_BITS-1:0]  job_cx,
   output logic [COORD_BITS-1:0]  job_cy,
   output logic [RADIUS_BITS-1:0] job_ox,
   output logic [RADIUS_BITS-1:0] job_oy,
   output logic                   job_last
);

   localparam int DEC_BITS = RADIUS_BITS + 3;
   localparam int DW       = RADIUS_BITS + 4;

   logic                   busy_ff, busy_in;
   logic [COORD_BITS-1:0]  cx_ff, cx_in;
   logic [COORD_BITS-1:0]  cy_ff, cy_in;
   logic [RADIUS_BITS-1:0] ring_ff, ring_in;
   logic [RADIUS_BITS-1:0] ox_ff, ox_in;
   logic [RADIUS_BITS-1:0] oy_ff, oy_in;
   logic [DEC_BITS-1:0]    dec_ff, dec_in;

   logic                   accept;
   logic                   is_step;
   logic signed [DW-1:0]   d_ext, ox_ext, oy_ext, r_ext;
   logic signed [DW-1:0]   d_next;
   logic [RADIUS_BITS:0]   ox_next, oy_next;
   logic                   ring_done;
   logic                   final_ring;

   always_comb begin
      accept  = req_valid && !req_stall;
      is_step = (fcr_pkg::cmd_type'(req_cmd) == fcr_pkg::CMD_STEP);

      d_ext  = DW'(signed'(dec_ff));
      ox_ext = signed'(DW'(ox_ff));
      oy_ext = signed'(DW'(oy_ff));
      r_ext  = signed'(DW'(ring_ff));

      ox_next = {1'b0, ox_ff};
      oy_next = {1'b0, oy_ff};
      priority if (d_ext >= (ox_ext <<< 1)) begin
         d_next  = d_ext - (ox_ext <<< 1) - DW'(1);
         ox_next = {1'b0, ox_ff} + 1'b1;
      end else if (d_ext < ((r_ext - oy_ext) <<< 1)) begin
         d_next  = d_ext + (oy_ext <<< 1) - DW'(1);
         oy_next = {1'b0, oy_ff} - 1'b1;
      end else begin
         d_next  = d_ext + ((oy_ext - ox_ext - DW'(1)) <<< 1);
         ox_next = {1'b0, ox_ff} + 1'b1;
         oy_next = {1'b0, oy_ff} - 1'b1;
      end
      ring_done  = (oy_next < ox_next);
      final_ring = (ring_ff <= RADIUS_BITS'(1));

      busy_in = busy_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      ring_in = ring_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      dec_in  = dec_ff;
      push    = 1'b0;

      if (accept && !is_step) begin
         cx_in   = req_center_x;
         cy_in   = req_center_y;
         ring_in = req_radius;
         ox_in   = '0;
         oy_in   = req_radius;
         dec_in  = DEC_BITS'(req_radius) - DEC_BITS'(1);
         busy_in = (req_radius != '0);
      end else if (accept && busy_ff) begin
         push   = 1'b1;
         ox_in  = ox_next[RADIUS_BITS-1:0];
         oy_in  = oy_next[RADIUS_BITS-1:0];
         dec_in = d_next[DEC_BITS-1:0];
         if (ring_done) begin
            if (final_ring) begin
               busy_in = 1'b0;
               ring_in = '0;
            end else begin
               // shrink to the next inner ring
               ring_in = ring_ff - 1'b1;
               ox_in   = '0;
               oy_in   = ring_ff - 1'b1;
               dec_in  = DEC_BITS'(ring_ff) - DEC_BITS'(2);
            end
         end
      end
   end

   assign req_stall = q_status.full;
   assign job_cx    = cx_ff;
   assign job_cy    = cy_ff;
   assign job_ox    = ox_ff;
   assign job_oy    = oy_ff;
   assign job_last  = ring_done && final_ring;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cx_ff   <= '0;
         cy_ff   <= '0;
         ring_ff <= '0;
         ox_ff   <= '0;
         oy_ff   <= '0;
         dec_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         ring_ff <= ring_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         dec_ff  <= dec_in;
      end
   end

   `FCR_ASSERT_IMPLY(a_busy_has_ring, clock, reset, busy_ff, ring_ff != '0)
   `FCR_ASSERT_IMPLY(a_busy_in_octant, clock, reset, busy_ff, oy_ff >= ox_ff)

endmodule

@@ hdl/fcr_back.sv @@
// ----------------------------------------------------------------------------
// fcr_back
// Expands a job into its eight symmetric pixels, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "filled_circle_rasterizer_macros.svh"

module fcr_back #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fcr_pkg::q_status_type        q_status,
   input  logic [COORD_BITS-1:0]        job_cx,
   input  logic [COORD_BITS-1:0]        job_cy,
   input  logic [RADIUS_BITS-1:0]       job_ox,
   input  logic [RADIUS_BITS-1:0]       job_oy,
   input  logic                         job_last,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS+1:0] rsp_point_x,
   output logic signed [COORD_BITS+1:0] rsp_point_y,
   output logic                         rsp_last
);

   localparam int OUT_BITS = COORD_BITS + 2;
   localparam int WW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

   logic [fcr_pkg::POINT_IDX_BITS-1:0] idx_ff, idx_in;
   logic                    valid_ff, valid_in;
   logic [OUT_BITS-1:0]     px_ff, px_in;
   logic [OUT_BITS-1:0]     py_ff, py_in;
   logic                    last_ff, last_in;

   logic                    load;
   logic [RADIUS_BITS-1:0]  off_a, off_b;
   logic [WW-1:0]           sum_x, sum_y;

   always_comb begin
      load = !q_status.empty && (!valid_ff || !rsp_stall);
      pop  = load && (idx_ff == fcr_pkg::LAST_POINT);

      // index bit 0 swaps the offsets, bit 1 negates x, bit 2 negates y
      off_a = idx_ff[0] ? job_oy : job_ox;
      off_b = idx_ff[0] ? job_ox : job_oy;
      sum_x = idx_ff[1] ? WW'(job_cx) - WW'(off_a) : WW'(job_cx) + WW'(off_a);
      sum_y = idx_ff[2] ? WW'(job_cy) - WW'(off_b) : WW'(job_cy) + WW'(off_b);

      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      px_in    = px_ff;
      py_in    = py_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = idx_ff + 1'b1;
         valid_in = 1'b1;
         px_in    = sum_x[OUT_BITS-1:0];
         py_in    = sum_y[OUT_BITS-1:0];
         last_in  = job_last && (idx_ff == fcr_pkg::LAST_POINT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_point_x = signed'(px_ff);
   assign rsp_point_y = signed'(py_ff);
   assign rsp_last    = last_ff;

   `FCR_ASSERT_NEXT(a_pop_rewinds_idx, clock, reset, pop, idx_ff == '0)

endmodule

@@ hdl/filled_circle_rasterizer.sv @@
// ----------------------------------------------------------------------------
// filled_circle_rasterizer
// Filled circle rasterizer built from concentric rings, outer to inner.
// ----------------------------------------------------------------------------
// A start request (cmd 0) latches center and radius and gives no pixels. Each
// step request (cmd 1) accepted while a circle is in progress advances the
// ring recurrence in the cycle it is accepted and queues one job; the back
// end turns every job into eight pixels, one per cycle while rsp_stall is low,
// so a steady stream of steps is paced by the result port. Up to two step jobs
// can wait in the queue, so requests keep being accepted while pixels are
// still draining. The last pixel of the radius-1 ring has rsp_last set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module filled_circle_rasterizer #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS+1:0] rsp_point_x,
   output logic signed [COORD_BITS+1:0] rsp_point_y,
   output logic                         rsp_last
);

   localparam int JOB_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

   fcr_pkg::q_status_type  q_status;
   logic                   push, pop;
   logic [JOB_BITS-1:0]    push_data, pop_data;
   logic [COORD_BITS-1:0]  in_cx, in_cy, out_cx, out_cy;
   logic [RADIUS_BITS-1:0] in_ox, in_oy, out_ox, out_oy;
   logic                   in_last, out_last;

   fcr_front #(
      .COORD_BITS (COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_radius  (req_radius),
      .q_status    (q_status),
      .push        (push),
      .job_cx      (in_cx),
      .job_cy      (in_cy),
      .job_ox      (in_ox),
      .job_oy      (in_oy),
      .job_last    (in_last)
   );

   assign push_data = {in_cx, in_cy, in_ox, in_oy, in_last};

   fcr_queue #(
      .WIDTH(JOB_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .status   (q_status)
   );

   assign {out_cx, out_cy, out_ox, out_oy, out_last} = pop_data;

   fcr_back #(
      .COORD_BITS (COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .job_cx     (out_cx),
      .job_cy     (out_cy),
      .job_ox     (out_ox),
      .job_oy     (out_oy),
      .job_last   (out_last),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y),
      .rsp_last   (rsp_last)
   );

endmodule
